@@ rtl/http_chunked_body_decoder_defines.svh @@
// assertion helpers shared by the decoder modules
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// checked only while out of reset
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/hcbd_pkg.sv @@
package hcbd_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 64;
  localparam logic [31:0] BODY_LIMIT_RESET = 32'd2097152;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [1:0] STATUS_BUSY     = 2'd0;
  localparam logic [1:0] STATUS_DONE     = 2'd1;
  localparam logic [1:0] STATUS_ERR_LINE = 2'd2;
  localparam logic [1:0] STATUS_ERR_BODY = 2'd3;

  // decoder phase
  typedef enum logic [6:0] {
    PH_LINE     = 7'b0000001,
    PH_DATA     = 7'b0000010,
    PH_TAIL     = 7'b0000100,
    PH_LAST     = 7'b0001000,
    PH_DONE     = 7'b0010000,
    PH_ERR_LINE = 7'b0100000,
    PH_ERR_BODY = 7'b1000000
  } phase_e;

  // size line digit scan
  typedef enum logic [2:0] {
    DM_BLANK = 3'b001,
    DM_DIGIT = 3'b010,
    DM_STOP  = 3'b100
  } digit_mode_e;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
  } item_t;

endpackage

@@ rtl/hcbd_front.sv @@
`include "http_chunked_body_decoder_defines.svh"

module hcbd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            first_byte_i,
  output logic            q_valid_o,
  output hcbd_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import hcbd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            item;
  item_t            slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             full, push, is_num, is_lc, is_uc;

  // classify the incoming word
  always_comb begin
    is_num = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
    is_lc  = (in_byte_i >= 8'h61) && (in_byte_i <= 8'h66);
    is_uc  = (in_byte_i >= 8'h41) && (in_byte_i <= 8'h46);
    item.data     = in_byte_i;
    item.first    = first_byte_i;
    item.is_hex   = is_num || is_lc || is_uc;
    item.digit    = is_num ? in_byte_i[3:0] : in_byte_i[3:0] + 4'd9;
    item.is_blank = (in_byte_i == CHAR_SP) || (in_byte_i == CHAR_TAB);
    item.is_cr    = (in_byte_i == CHAR_CR);
    item.is_lf    = (in_byte_i == CHAR_LF);
  end

  assign full       = (count_q == CntW'(Depth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  `HCBD_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `HCBD_ASSERT(a_pop_nonempty, q_pop_i |-> (count_q != '0), "pop from empty queue")
  `HCBD_ASSERT(a_count_track, $past(rst_ni) |-> (count_q == CntW'($past(count_q) + CntW'($past(push)) - CntW'($past(q_pop_i)))), "queue count drift")

endmodule

@@ rtl/hcbd_back.sv @@
`include "http_chunked_body_decoder_defines.svh"

module hcbd_back #(
  parameter int unsigned LINE_LIMIT = hcbd_pkg::LINE_LIMIT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     body_limit_i,
  input  logic            q_valid_i,
  input  hcbd_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            data_valid_o,
  output logic [7:0]      data_byte_o,
  output logic [1:0]      status_o,
  output logic [31:0]     body_length_o
);
  import hcbd_pkg::*;

  localparam int unsigned LcW = $clog2(LINE_LIMIT);

  phase_e      phase_q, phase_d, ph;
  digit_mode_e dm_q, dm_d, dm;
  logic [LcW-1:0] line_q, line_d, line_c;
  logic [31:0] hex_q, hex_d, hex_c;
  logic        cr_q, cr_d, cr_c;
  logic [31:0] left_q, left_d, left_c;
  logic [1:0]  tail_q, tail_d, tail_c;
  logic [31:0] total_q, total_d, total_c;
  logic [32:0] sum;
  logic        can_load;

  logic        out_valid_q;
  logic        data_valid_q, data_valid_d;
  logic [7:0]  data_byte_q, data_byte_d;
  logic [1:0]  status_q, status_d;

  assign can_load = !out_valid_q || !out_stall_i;
  assign q_pop_o  = q_valid_i && can_load;

  // a new body starts from the cleared state
  always_comb begin
    if (q_item_i.first) begin
      ph      = PH_LINE;
      dm      = DM_BLANK;
      line_c  = '0;
      hex_c   = '0;
      cr_c    = 1'b0;
      left_c  = '0;
      tail_c  = '0;
      total_c = '0;
    end else begin
      ph      = phase_q;
      dm      = dm_q;
      line_c  = line_q;
      hex_c   = hex_q;
      cr_c    = cr_q;
      left_c  = left_q;
      tail_c  = tail_q;
      total_c = total_q;
    end
  end

  always_comb begin
    phase_d      = ph;
    dm_d         = dm;
    line_d       = line_c;
    hex_d        = hex_c;
    cr_d         = cr_c;
    left_d       = left_c;
    tail_d       = tail_c;
    total_d      = total_c;
    data_valid_d = 1'b0;
    data_byte_d  = '0;
    sum          = {1'b0, total_c} + {1'b0, hex_c};
    unique case (ph)
      PH_LINE: begin
        line_d = line_c + 1'b1;
        if (cr_c && q_item_i.is_lf) begin
          if (sum > {1'b0, body_limit_i}) begin
            phase_d = PH_ERR_BODY;
          end else if (hex_c == '0) begin
            phase_d = PH_LAST;
            tail_d  = '0;
          end else begin
            phase_d = PH_DATA;
            left_d  = hex_c;
          end
        end else begin
          if (dm != DM_STOP && !(dm == DM_BLANK && q_item_i.is_blank)) begin
            if (!q_item_i.is_hex) begin
              dm_d = DM_STOP;
            end else begin
              dm_d  = DM_DIGIT;
              // saturate once a further digit would overflow 32 bits
              hex_d = (|hex_c[31:28]) ? '1 : {hex_c[27:0], q_item_i.digit};
            end
          end
          cr_d = q_item_i.is_cr;
          if (line_d >= LcW'(LINE_LIMIT - 1)) begin
            phase_d = PH_ERR_LINE;
          end
        end
      end
      PH_DATA: begin
        data_valid_d = 1'b1;
        data_byte_d  = q_item_i.data;
        total_d      = total_c + 1'b1;
        left_d       = left_c - 1'b1;
        if (left_d == '0) begin
          phase_d = PH_TAIL;
          tail_d  = '0;
        end
      end
      PH_TAIL: begin
        tail_d = tail_c + 1'b1;
        if (tail_d >= 2'd2) begin
          phase_d = PH_LINE;
          line_d  = '0;
          hex_d   = '0;
          dm_d    = DM_BLANK;
          cr_d    = 1'b0;
        end
      end
      PH_LAST: begin
        tail_d = tail_c + 1'b1;
        if (tail_d >= 2'd2) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE, PH_ERR_LINE, PH_ERR_BODY: begin
      end
      default: begin
      end
    endcase
    unique case (phase_d)
      PH_DONE:     status_d = STATUS_DONE;
      PH_ERR_LINE: status_d = STATUS_ERR_LINE;
      PH_ERR_BODY: status_d = STATUS_ERR_BODY;
      default:     status_d = STATUS_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LINE;
      dm_q        <= DM_BLANK;
      line_q      <= '0;
      hex_q       <= '0;
      cr_q        <= 1'b0;
      left_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= phase_d;
        dm_q    <= dm_d;
        line_q  <= line_d;
        hex_q   <= hex_d;
        cr_q    <= cr_d;
        left_q  <= left_d;
        tail_q  <= tail_d;
        total_q <= total_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_valid_q <= data_valid_d;
      data_byte_q  <= data_byte_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_valid_o  = data_valid_q;
  assign data_byte_o   = data_byte_q;
  assign status_o      = status_q;
  assign body_length_o = total_q;

  `HCBD_ASSERT(a_data_busy, (out_valid_q && data_valid_q) |-> (status_q == STATUS_BUSY), "payload word with final status")
  `HCBD_ASSERT(a_left_live, (phase_q == PH_DATA) |-> (left_q != '0), "data phase with nothing left")
  `HCBD_ASSERT(a_tail_bound, ((phase_q == PH_TAIL) || (phase_q == PH_LAST)) |-> (tail_q < 2'd2), "tail counter overran")

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// a word accepted into the queue is decoded, and its result word is held in the output register
// one word per cycle unless out_stall_i holds the output; the decode state updates on each popped word
// a two-entry queue sits between input classification and the decode state machine
// reset (rst_ni low, asynchronous) empties the queue and output register, clears
// the decode state and sets body_limit to 2097152
module http_chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT = hcbd_pkg::LINE_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        first_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  status_o,
  output logic [31:0] body_length_o,
  // body limit register
  input  logic        body_limit_we_i,
  input  logic [31:0] body_limit_i
);
  import hcbd_pkg::*;

  logic [31:0] body_limit_q;
  logic        q_valid, q_pop;
  item_t       q_item;

  // configuration register; the user must write it only while the decoder is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_limit_q <= BODY_LIMIT_RESET;
    end else if (body_limit_we_i) begin
      body_limit_q <= body_limit_i;
    end
  end

  // front: classify each byte (hex digit, blank, cr, lf) and queue it
  hcbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  // back: chunk state machine, size parse, limit check and output register
  hcbd_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .body_limit_i  (body_limit_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .body_length_o (body_length_o)
  );

endmodule
